// ===== src/assert_macros.svh =====
// Assertion macros shared by the generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`endif
`endif

// ===== src/srng_pkg.sv =====
// Types, constants and codes of the subtractive lagged generator.
package srng_pkg;

   localparam int SEED_BITS          = 30;
   localparam int DRAW_BITS          = 31;
   localparam int TABLE_DEPTH        = 56;
   localparam int TABLE_LAST         = 55;
   localparam int IDX_BITS           = $clog2(TABLE_DEPTH);
   localparam int FILL_STRIDE        = 21;
   localparam int FILL_COUNT         = 54;
   localparam int MIX_PASSES         = 4;
   localparam int LAG_OFFSET         = 30;
   localparam int LAG_START          = 31;
   localparam int MIX_STEPS          = MIX_PASSES * TABLE_LAST;
   localparam int MIX_WRAP           = TABLE_LAST - LAG_OFFSET - 1;
   localparam int STEP_BITS          = $clog2(MIX_STEPS);
   localparam int WORD_WIDTH_DEFAULT = 32;
   localparam int CSR_DATA_BITS      = 32;
   localparam int CSR_ADDR_BITS      = 4;

   localparam logic [SEED_BITS-1:0] MODULUS_RESET   = 30'd1000000000;
   localparam logic [SEED_BITS-1:0] SEED_BASE_RESET = 30'd161803398;

   typedef enum logic [1:0] {
      CSR_MODULUS   = 2'd0,
      CSR_SEED_BASE = 2'd1,
      CSR_FLOOR     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REM,
      ST_FILL,
      ST_MIX,
      ST_DRAW_READ,
      ST_DRAW_WRITE
   } srng_state_type;

   typedef struct packed {
      logic rem_start;
      logic seed_load;
      logic fill_step;
      logic mix_issue;
      logic draw_issue;
      logic draw_write;
   } srng_cmd_type;

   typedef struct packed {
      logic rem_done;
      logic out_free;
   } srng_status_type;

endpackage

// ===== src/srng_if.sv =====
// Request and response channel interfaces of the generator.
interface srng_req_if;
   logic                           valid;
   logic                           ready;
   logic                           reseed;
   logic [srng_pkg::SEED_BITS-1:0] seed_magnitude;

   modport source (output valid, reseed, seed_magnitude, input ready);
   modport sink (input valid, reseed, seed_magnitude, output ready);
endinterface

interface srng_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [srng_pkg::DRAW_BITS-1:0] draw;

   modport source (output valid, draw, input ready);
   modport sink (input valid, draw, output ready);
endinterface

// ===== src/srng_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module srng_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 56
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== src/srng_rem.sv =====
// Restoring remainder unit: one dividend bit per cycle.
module srng_rem (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [srng_pkg::SEED_BITS-1:0] dividend,
   input  logic [srng_pkg::SEED_BITS-1:0] divisor,
   output logic                           done,
   output logic [srng_pkg::SEED_BITS-1:0] remainder
);

   localparam int NB = srng_pkg::SEED_BITS;
   localparam int CNT_BITS = $clog2(NB);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NB-1:0]       dvd_ff, dvd_in;
   logic [NB-1:0]       rem_ff, rem_in;
   logic [NB:0]         trial;
   logic                fits;
   logic                last;

   // Zero divisor never fails the compare, so the dividend passes through.
   assign trial = {rem_ff, dvd_ff[NB-1]};
   assign fits  = trial >= {1'b0, divisor};
   assign last  = cnt_ff == CNT_BITS'(NB - 1);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? NB'(trial - {1'b0, divisor}) : trial[NB-1:0];
         dvd_in  = {dvd_ff[NB-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/srng_dp.sv =====
// Datapath: lag table, seed reduction, fill, mixing and draw arithmetic.
module srng_dp #(
   parameter int WORD_WIDTH = srng_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  srng_pkg::srng_cmd_type          cmd,
   output srng_pkg::srng_status_type       status,
   input  logic [srng_pkg::SEED_BITS-1:0]  seed_magnitude,
   input  logic [srng_pkg::SEED_BITS-1:0]  modulus,
   input  logic [srng_pkg::SEED_BITS-1:0]  seed_base,
   input  logic                            floor_value,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [srng_pkg::DRAW_BITS-1:0]  rsp_draw
);

   localparam int NB = srng_pkg::SEED_BITS;
   localparam int IB = srng_pkg::IDX_BITS;
   localparam int W  = WORD_WIDTH;

   function automatic logic [IB-1:0] next_index(input logic [IB-1:0] idx);
      return (idx == IB'(srng_pkg::TABLE_LAST)) ? IB'(1) : IB'(idx + 1'b1);
   endfunction

   logic [NB:0]     seed_diff;
   logic [NB:0]     seed_neg;
   logic            diff_neg;
   logic [NB-1:0]   seed_mag;
   logic            rem_done;
   logic [NB-1:0]   rem_value;
   logic [W-1:0]    rem_word;
   logic [W-1:0]    seed_word;

   logic            neg_ff, neg_in;
   logic [W-1:0]    mj_ff, mj_in;
   logic [W-1:0]    mk_ff, mk_in;
   logic [IB-1:0]   pos_ff, pos_in;
   logic [IB-1:0]   mix_i_ff, mix_i_in;
   logic            mix_wr_ff;
   logic [IB-1:0]   mix_wr_addr_ff, mix_wr_addr_in;
   logic [IB-1:0]   read_idx_ff, read_idx_in;
   logic [IB-1:0]   lag_idx_ff, lag_idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [srng_pkg::DRAW_BITS-1:0] rsp_draw_ff, rsp_draw_in;

   logic [IB:0]     pos_sum;
   logic [IB-1:0]   pos_next;
   logic [IB-1:0]   mix_j;
   logic [IB-1:0]   read_next;
   logic [IB-1:0]   lag_next;

   logic [W-1:0]    rd_a;
   logic [W-1:0]    rd_b;
   logic [W-1:0]    op_a;
   logic [W-1:0]    op_b;
   logic [W-1:0]    diff_w;
   logic            below;
   logic [W-1:0]    sub_result;

   logic            wr_en;
   logic [IB-1:0]   wr_addr;
   logic [W-1:0]    wr_data;
   logic [IB-1:0]   rd_addr_a;
   logic [IB-1:0]   rd_addr_b;

   // Seed: base minus magnitude, magnitude reduced by modulus, sign restored after.
   assign seed_diff = {1'b0, seed_base} - {1'b0, seed_magnitude};
   assign seed_neg  = '0 - seed_diff;
   assign diff_neg  = seed_diff[NB];
   assign seed_mag  = diff_neg ? seed_neg[NB-1:0] : seed_diff[NB-1:0];

   srng_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.rem_start),
      .dividend  (seed_mag),
      .divisor   (modulus),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign rem_word  = {{(W - NB){1'b0}}, rem_value};
   assign seed_word = neg_ff ? ('0 - rem_word) : rem_word;

   assign pos_sum  = {1'b0, pos_ff} + (IB + 1)'(srng_pkg::FILL_STRIDE);
   assign pos_next = (pos_sum >= (IB + 1)'(srng_pkg::TABLE_LAST))
                   ? IB'(pos_sum - (IB + 1)'(srng_pkg::TABLE_LAST))
                   : pos_sum[IB-1:0];

   // Partner entry of the mixing pass, cyclic over 1..55.
   assign mix_j = (mix_i_ff <= IB'(srng_pkg::MIX_WRAP))
                ? IB'(mix_i_ff + IB'(srng_pkg::LAG_OFFSET + 1))
                : IB'(mix_i_ff - IB'(srng_pkg::MIX_WRAP));

   assign read_next = next_index(read_idx_ff);
   assign lag_next  = next_index(lag_idx_ff);

   // Shared subtract with floor correction.
   assign op_a       = cmd.fill_step ? mj_ff : rd_a;
   assign op_b       = cmd.fill_step ? mk_ff : rd_b;
   assign diff_w     = op_a - op_b;
   assign below      = diff_w[W-1] | (floor_value & (diff_w == '0));
   assign sub_result = below ? (diff_w + {{(W - NB){1'b0}}, modulus}) : diff_w;

   always_comb begin
      rd_addr_a = read_idx_ff;
      rd_addr_b = lag_idx_ff;
      if (cmd.mix_issue) begin
         rd_addr_a = mix_i_ff;
         rd_addr_b = mix_j;
      end else if (cmd.draw_issue) begin
         rd_addr_a = read_next;
         rd_addr_b = lag_next;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = read_idx_ff;
      wr_data = sub_result;
      if (cmd.seed_load) begin
         wr_en   = 1'b1;
         wr_addr = IB'(srng_pkg::TABLE_LAST);
         wr_data = seed_word;
      end else if (cmd.fill_step) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff;
         wr_data = mk_ff;
      end else if (mix_wr_ff) begin
         wr_en   = 1'b1;
         wr_addr = mix_wr_addr_ff;
      end else if (cmd.draw_write) begin
         wr_en   = 1'b1;
      end
   end

   srng_ram #(
      .WIDTH (W),
      .DEPTH (srng_pkg::TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   always_comb begin
      neg_in         = neg_ff;
      mj_in          = mj_ff;
      mk_in          = mk_ff;
      pos_in         = pos_ff;
      mix_i_in       = mix_i_ff;
      mix_wr_addr_in = mix_wr_addr_ff;
      read_idx_in    = read_idx_ff;
      lag_idx_in     = lag_idx_ff;
      rsp_draw_in    = rsp_draw_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      if (cmd.rem_start) begin
         neg_in = diff_neg;
      end
      if (cmd.seed_load) begin
         mj_in       = seed_word;
         mk_in       = W'(1);
         pos_in      = IB'(srng_pkg::FILL_STRIDE);
         mix_i_in    = IB'(1);
         read_idx_in = '0;
         lag_idx_in  = IB'(srng_pkg::LAG_START);
      end
      if (cmd.fill_step) begin
         mk_in  = sub_result;
         mj_in  = mk_ff;
         pos_in = pos_next;
      end
      if (cmd.mix_issue) begin
         mix_i_in       = next_index(mix_i_ff);
         mix_wr_addr_in = mix_i_ff;
      end
      if (cmd.draw_issue) begin
         read_idx_in = read_next;
         lag_idx_in  = lag_next;
      end
      if (cmd.draw_write) begin
         rsp_draw_in  = sub_result[srng_pkg::DRAW_BITS-1:0];
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_wr_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         read_idx_ff  <= '0;
         lag_idx_ff   <= IB'(srng_pkg::LAG_START);
      end else begin
         mix_wr_ff    <= cmd.mix_issue;
         rsp_valid_ff <= rsp_valid_in;
         read_idx_ff  <= read_idx_in;
         lag_idx_ff   <= lag_idx_in;
      end
      neg_ff         <= neg_in;
      mj_ff          <= mj_in;
      mk_ff          <= mk_in;
      pos_ff         <= pos_in;
      mix_i_ff       <= mix_i_in;
      mix_wr_addr_ff <= mix_wr_addr_in;
      rsp_draw_ff    <= rsp_draw_in;
   end

   assign status.rem_done = rem_done;
   assign status.out_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_draw        = rsp_draw_ff;

endmodule

// ===== src/srng_ctrl.sv =====
// Controller: sequences rebuild, mixing passes and draws.
module srng_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_reseed,
   output logic                      req_ready,
   input  srng_pkg::srng_status_type status,
   output srng_pkg::srng_cmd_type    cmd
);

   localparam int SB = srng_pkg::STEP_BITS;

   srng_pkg::srng_state_type state_ff, state_in;
   logic [SB-1:0]            step_ff, step_in;
   logic                     seeded_ff, seeded_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= srng_pkg::ST_IDLE;
         step_ff   <= '0;
         seeded_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         seeded_ff <= seeded_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      seeded_in = seeded_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         srng_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_reseed || !seeded_ff) begin
                  cmd.rem_start = 1'b1;
                  state_in      = srng_pkg::ST_REM;
               end else begin
                  cmd.draw_issue = 1'b1;
                  state_in       = srng_pkg::ST_DRAW_WRITE;
               end
            end
         end
         srng_pkg::ST_REM: begin
            if (status.rem_done) begin
               cmd.seed_load = 1'b1;
               step_in       = '0;
               state_in      = srng_pkg::ST_FILL;
            end
         end
         srng_pkg::ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (step_ff == SB'(srng_pkg::FILL_COUNT - 1)) begin
               step_in  = '0;
               state_in = srng_pkg::ST_MIX;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         srng_pkg::ST_MIX: begin
            cmd.mix_issue = 1'b1;
            if (step_ff == SB'(srng_pkg::MIX_STEPS - 1)) begin
               step_in   = '0;
               seeded_in = 1'b1;
               state_in  = srng_pkg::ST_DRAW_READ;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         srng_pkg::ST_DRAW_READ: begin
            cmd.draw_issue = 1'b1;
            state_in       = srng_pkg::ST_DRAW_WRITE;
         end
         srng_pkg::ST_DRAW_WRITE: begin
            // hold the read until the response slot frees up
            if (status.out_free) begin
               cmd.draw_write = 1'b1;
               state_in       = srng_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srng_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/subtractive_lagged_rng.sv =====
// Draw without rebuild: accept issues the table reads, then the write state waits for a free
// response slot and registers the word; no new request is accepted until the draw completes.
// Rebuild (first request after reset or reseed set) adds a bit-serial remainder, 1 seed write,
// 54 fill writes and 220 mixing writes, paced by the single write port of the lag table.
// Reset clears control state and loads register defaults; table is rebuilt on first use.
`include "assert_macros.svh"

module subtractive_lagged_rng #(
   parameter int WORD_WIDTH = srng_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   srng_req_if.sink                           req,
   srng_rsp_if.source                         rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [srng_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [srng_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [srng_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   localparam int NB = srng_pkg::SEED_BITS;
   localparam int DB = srng_pkg::CSR_DATA_BITS;

   logic [NB-1:0]             modulus_ff, modulus_in;
   logic [NB-1:0]             seed_base_ff, seed_base_in;
   logic                      floor_ff, floor_in;
   logic                      csr_write;
   srng_pkg::csr_index_type   csr_index;
   srng_pkg::srng_cmd_type    cmd;
   srng_pkg::srng_status_type status;
   logic                      rsp_valid;
   logic [srng_pkg::DRAW_BITS-1:0] rsp_draw;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = srng_pkg::csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      modulus_in   = modulus_ff;
      seed_base_in = seed_base_ff;
      floor_in     = floor_ff;
      if (csr_write) begin
         case (csr_index)
            srng_pkg::CSR_MODULUS:   modulus_in   = csr_pwdata[NB-1:0];
            srng_pkg::CSR_SEED_BASE: seed_base_in = csr_pwdata[NB-1:0];
            srng_pkg::CSR_FLOOR:     floor_in     = csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         srng_pkg::CSR_MODULUS:   csr_prdata = DB'(modulus_ff);
         srng_pkg::CSR_SEED_BASE: csr_prdata = DB'(seed_base_ff);
         srng_pkg::CSR_FLOOR:     csr_prdata = DB'(floor_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= srng_pkg::MODULUS_RESET;
         seed_base_ff <= srng_pkg::SEED_BASE_RESET;
         floor_ff     <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         seed_base_ff <= seed_base_in;
         floor_ff     <= floor_in;
      end
   end

   srng_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_reseed (req.reseed),
      .req_ready  (req.ready),
      .status     (status),
      .cmd        (cmd)
   );

   srng_dp #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .seed_magnitude (req.seed_magnitude),
      .modulus        (modulus_ff),
      .seed_base      (seed_base_ff),
      .floor_value    (floor_ff),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp_valid),
      .rsp_draw       (rsp_draw)
   );

   assign rsp.valid = rsp_valid;
   assign rsp.draw  = $signed(rsp_draw);

   `ASSERT_NEXT(a_one_in_flight, clock, reset, req.valid && req.ready, !req.ready)
   `ASSERT_IMP(a_slot_free_on_write, clock, reset, cmd.draw_write, status.out_free)
   `ASSERT_ALWAYS(a_single_writer, clock, reset, $onehot0({cmd.seed_load, cmd.fill_step, cmd.draw_write}))
   `ASSERT_NEXT(a_rsp_from_draw, clock, reset, !rsp.valid && !cmd.draw_write, !rsp.valid)

endmodule
